// File: hdl/kwm_pkg.sv
package kwm_pkg;

    // Default storage depths.
    localparam int KEY_DEPTH_DEF    = 16;
    localparam int RECENT_DEPTH_DEF = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_RECENT_LIMIT = 2'd0;
    localparam logic [1:0] REG_MATCH_RATIO  = 2'd1;
    localparam logic [1:0] REG_UNUSED_LIMIT = 2'd2;
    localparam logic [1:0] REG_KEY_CAP      = 2'd3;

    // Configuration reset values.
    localparam logic [2:0]  RECENT_LIMIT_RST = 3'd4;
    localparam logic [15:0] MATCH_RATIO_RST  = 16'd128;
    localparam logic [7:0]  UNUSED_LIMIT_RST = 8'd5;
    localparam logic [3:0]  KEY_CAP_RST      = 4'd0;

    localparam int CFG_DATA_W = 16;
    localparam int INDEX_W    = 32;
    localparam int SIZE_W     = 20;
    localparam int CONN_W     = 24;
    localparam int UNUSED_W   = 8;

    // Request from the step sequencer to the result buffer.
    typedef struct packed {
        logic               push;
        logic               flush;
        logic [INDEX_W-1:0] idx;
        logic               forced;
    } t_buf_req;

    // Status of the result buffer.
    typedef struct packed {
        logic ready;
        logic pending;
    } t_buf_sts;

endpackage

// File: hdl/kwm_out.sv
module kwm_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kwm_pkg::t_buf_req               i_req,
    output kwm_pkg::t_buf_sts               o_sts,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [kwm_pkg::INDEX_W-1:0]     o_marginal_index,
    output logic                            o_last_of_step,
    output logic                            o_forced_evict
);

    // One word is held back so that the last word of a step can be flagged.
    logic                        r_pv, n_pv;
    logic [kwm_pkg::INDEX_W-1:0] r_pidx, n_pidx;
    logic                        r_pf, n_pf;
    logic                        r_ov, n_ov;
    logic [kwm_pkg::INDEX_W-1:0] r_oidx, n_oidx;
    logic                        r_olast, n_olast;
    logic                        r_of, n_of;
    logic                        ready;

    assign ready = !r_pv || !r_ov || !i_stall;

    // Move the held word out when a new one arrives or the step ends.
    always_comb begin
        n_pv    = r_pv;
        n_pidx  = r_pidx;
        n_pf    = r_pf;
        n_ov    = r_ov && i_stall;
        n_oidx  = r_oidx;
        n_olast = r_olast;
        n_of    = r_of;
        if (i_req.push && ready) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_oidx  = r_pidx;
                n_olast = 1'b0;
                n_of    = r_pf;
            end
            n_pv   = 1'b1;
            n_pidx = i_req.idx;
            n_pf   = i_req.forced;
        end else if (i_req.flush && ready && r_pv) begin
            n_ov    = 1'b1;
            n_oidx  = r_pidx;
            n_olast = 1'b1;
            n_of    = r_pf;
            n_pv    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= n_pv;
            r_ov <= n_ov;
        end
        r_pidx  <= n_pidx;
        r_pf    <= n_pf;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
        r_of    <= n_of;
    end

    assign o_sts.ready      = ready;
    assign o_sts.pending    = r_pv;
    assign o_valid          = r_ov;
    assign o_marginal_index = r_oidx;
    assign o_last_of_step   = r_olast;
    assign o_forced_evict   = r_of;

endmodule

// File: hdl/keyframe_window_manager_unit.sv
// Sequence: a report word walks the held keyframes, then the recent frames.
// A frame word runs the window judgement and an unused pass over the keyframes,
// plus a grouping and compaction pass when keyframes expire; words leave in order.
// Throughput: one word at a time; the keyframe memory walk sets the rate.
// Reset: synchronous, active low; empties both stores, loads register defaults.
// Memories need no clearing pass; connection counts use per-slot flags.
module keyframe_window_manager_unit #(
    parameter int KEY_DEPTH    = kwm_pkg::KEY_DEPTH_DEF,
    parameter int RECENT_DEPTH = kwm_pkg::RECENT_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [kwm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic [kwm_pkg::INDEX_W-1:0]        i_frame_index,
    input  logic [kwm_pkg::SIZE_W-1:0]         i_frame_size,
    input  logic [kwm_pkg::CONN_W-1:0]         i_connection_count,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [kwm_pkg::INDEX_W-1:0]        o_marginal_index,
    output logic                               o_last_of_step,
    output logic                               o_forced_evict
);

    localparam int KAW = $clog2(KEY_DEPTH);
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam int RAW = $clog2(RECENT_DEPTH);
    localparam int RCW = $clog2(RECENT_DEPTH + 1);
    localparam int IW  = (KCW > RCW) ? KCW : RCW;
    localparam int MW  = 36;
    localparam int PW  = MW + RCW;
    localparam int IXW = kwm_pkg::INDEX_W;
    localparam int SZW = kwm_pkg::SIZE_W;
    localparam int CNW = kwm_pkg::CONN_W;
    localparam int UNW = kwm_pkg::UNUSED_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RK_RD  = 5'd1;
    localparam logic [4:0] S_RK_EX  = 5'd2;
    localparam logic [4:0] S_RR_RD  = 5'd3;
    localparam logic [4:0] S_RR_EX  = 5'd4;
    localparam logic [4:0] S_PUSH   = 5'd5;
    localparam logic [4:0] S_KPUSH  = 5'd6;
    localparam logic [4:0] S_KFULL  = 5'd7;
    localparam logic [4:0] S_KWR    = 5'd8;
    localparam logic [4:0] S_J0     = 5'd9;
    localparam logic [4:0] S_J1     = 5'd10;
    localparam logic [4:0] S_J2     = 5'd11;
    localparam logic [4:0] S_J3     = 5'd12;
    localparam logic [4:0] S_U_INIT = 5'd13;
    localparam logic [4:0] S_U_RD   = 5'd14;
    localparam logic [4:0] S_U_EX   = 5'd15;
    localparam logic [4:0] S_G_SEL  = 5'd16;
    localparam logic [4:0] S_G_KEY  = 5'd17;
    localparam logic [4:0] S_G_RD   = 5'd18;
    localparam logic [4:0] S_G_EX   = 5'd19;
    localparam logic [4:0] S_C_RD   = 5'd20;
    localparam logic [4:0] S_C_EX   = 5'd21;
    localparam logic [4:0] S_CAP    = 5'd22;
    localparam logic [4:0] S_CAP_EX = 5'd23;
    localparam logic [4:0] S_END    = 5'd24;

    // Physical slot of a logical position in a ring.
    function automatic logic [KAW-1:0] kphys(input logic [KAW-1:0] b, input logic [IW-1:0] o);
        int s;
        s = int'(b) + int'(o);
        if (s >= KEY_DEPTH) s = s - KEY_DEPTH;
        return KAW'(s);
    endfunction

    function automatic logic [RAW-1:0] rphys(input logic [RAW-1:0] b, input logic [IW-1:0] o);
        int s;
        s = int'(b) + int'(o);
        if (s >= RECENT_DEPTH) s = s - RECENT_DEPTH;
        return RAW'(s);
    endfunction

    // Configuration registers.
    logic [2:0]  r_cfg_rl;
    logic [15:0] r_cfg_ratio;
    logic [7:0]  r_cfg_ul;
    logic [3:0]  r_cfg_cap;

    // Control state.
    logic [4:0]            r_state, n_state;
    logic [KAW-1:0]        r_kh, n_kh;
    logic [KCW-1:0]        r_kc, n_kc;
    logic [RAW-1:0]        r_rh, n_rh;
    logic [RCW-1:0]        r_rc, n_rc;
    logic [IW-1:0]         r_i, n_i;
    logic [IW-1:0]         r_j, n_j;
    logic [IW-1:0]         r_w, n_w;
    logic [KEY_DEPTH-1:0]  r_done, n_done;
    logic [KEY_DEPTH-1:0]  r_gone, n_gone;
    logic [KEY_DEPTH-1:0]  r_kflag, n_kflag;
    logic [RECENT_DEPTH-1:0] r_rflag, n_rflag;
    logic                  r_any, n_any;
    logic                  r_ret, n_ret;
    logic                  r_cforced, n_cforced;

    // Working registers.
    logic [IXW-1:0] r_fidx, n_fidx;
    logic [SZW-1:0] r_fsize, n_fsize;
    logic [CNW-1:0] r_fconn, n_fconn;
    logic [IXW-1:0] r_pidx, n_pidx;
    logic [CNW-1:0] r_pconn, n_pconn;
    logic          r_pflag, n_pflag;
    logic [RAW-1:0] r_jslot, n_jslot;
    logic [IXW-1:0] r_jidx, n_jidx;
    logic [CNW-1:0] r_jconn, n_jconn;
    logic [MW-1:0]  r_prod, n_prod;
    logic [PW-1:0]  r_rhs, n_rhs;
    logic [IXW-1:0] r_gkey, n_gkey;

    // Memories and their ports.
    logic [IXW-1:0] r_kmem_idx  [KEY_DEPTH];
    logic [UNW-1:0] r_kmem_un   [KEY_DEPTH];
    logic [CNW-1:0] r_kmem_conn [KEY_DEPTH];
    logic [IXW-1:0] r_rmem_idx  [RECENT_DEPTH];
    logic [SZW-1:0] r_rmem_size [RECENT_DEPTH];
    logic [CNW-1:0] r_rmem_conn [RECENT_DEPTH];
    logic [KAW-1:0] r_kra, k_raddr;
    logic [RAW-1:0] r_rra, rm_raddr;
    logic [IXW-1:0] r_kq_idx;
    logic [UNW-1:0] r_kq_un;
    logic [CNW-1:0] r_kq_conn;
    logic [IXW-1:0] r_rq_idx;
    logic [SZW-1:0] r_rq_size;
    logic [CNW-1:0] r_rq_conn;
    logic           k_we_idx, k_we_un, k_we_conn;
    logic [KAW-1:0] k_waddr;
    logic [IXW-1:0] k_wd_idx;
    logic [UNW-1:0] k_wd_un;
    logic [CNW-1:0] k_wd_conn;
    logic           rm_we_main, rm_we_conn;
    logic [RAW-1:0] rm_waddr;
    logic [CNW-1:0] rm_wd_conn;

    kwm_pkg::t_buf_req buf_req;
    kwm_pkg::t_buf_sts buf_sts;

    // Working values of the current slot.
    logic [KAW-1:0] kslot;
    logic [RAW-1:0] rslot;
    logic [CNW-1:0] kconn_eff;
    logic [UNW-1:0] un_next;
    logic           un_done;
    int             lim;

    assign kslot     = kphys(r_kh, r_i);
    assign rslot     = rphys(r_rh, r_i);
    assign kconn_eff = r_kflag[kslot] ? r_kq_conn : '0;
    assign un_next   = (kconn_eff != '0) ? '0 :
                       ((r_kq_un == '1) ? r_kq_un : r_kq_un + UNW'(1));
    assign un_done   = un_next > r_cfg_ul;
    assign lim       = (int'(r_cfg_rl) > RECENT_DEPTH - 1) ? RECENT_DEPTH - 1 : int'(r_cfg_rl);

    assign o_stall = (r_state != S_IDLE);

    // Step and report sequencer.
    always_comb begin
        n_state   = r_state;
        n_kh      = r_kh;
        n_kc      = r_kc;
        n_rh      = r_rh;
        n_rc      = r_rc;
        n_i       = r_i;
        n_j       = r_j;
        n_w       = r_w;
        n_done    = r_done;
        n_gone    = r_gone;
        n_kflag   = r_kflag;
        n_rflag   = r_rflag;
        n_any     = r_any;
        n_ret     = r_ret;
        n_cforced = r_cforced;
        n_fidx    = r_fidx;
        n_fsize   = r_fsize;
        n_fconn   = r_fconn;
        n_pidx    = r_pidx;
        n_pconn   = r_pconn;
        n_pflag   = r_pflag;
        n_jslot   = r_jslot;
        n_jidx    = r_jidx;
        n_jconn   = r_jconn;
        n_prod    = r_prod;
        n_rhs     = r_rhs;
        n_gkey    = r_gkey;
        k_raddr    = r_kra;
        rm_raddr   = r_rra;
        k_we_idx   = 1'b0;
        k_we_un    = 1'b0;
        k_we_conn  = 1'b0;
        k_waddr    = kslot;
        k_wd_idx   = r_kq_idx;
        k_wd_un    = '0;
        k_wd_conn  = r_fconn;
        rm_we_main = 1'b0;
        rm_we_conn = 1'b0;
        rm_waddr   = rslot;
        rm_wd_conn = r_fconn;
        buf_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_fidx  = i_frame_index;
                    n_fsize = i_frame_size;
                    n_fconn = i_connection_count;
                    n_i     = '0;
                    n_state = i_mode ? S_PUSH : S_RK_RD;
                end
            end
            // Report: walk the keyframes, then the recent frames.
            S_RK_RD: begin
                if (int'(r_i) >= int'(r_kc)) begin
                    n_i     = '0;
                    n_state = S_RR_RD;
                end else begin
                    k_raddr = kslot;
                    n_state = S_RK_EX;
                end
            end
            S_RK_EX: begin
                if (r_kq_idx == r_fidx) begin
                    k_we_conn      = 1'b1;
                    n_kflag[kslot] = 1'b1;
                end
                n_i     = r_i + IW'(1);
                n_state = S_RK_RD;
            end
            S_RR_RD: begin
                if (int'(r_i) >= int'(r_rc)) begin
                    n_state = S_IDLE;
                end else begin
                    rm_raddr = rslot;
                    n_state  = S_RR_EX;
                end
            end
            S_RR_EX: begin
                if (r_rq_idx == r_fidx) begin
                    rm_we_conn     = 1'b1;
                    n_rflag[rslot] = 1'b1;
                end
                n_i     = r_i + IW'(1);
                n_state = S_RR_RD;
            end
            // New frame: keyframe for index zero, recent frame otherwise.
            S_PUSH: begin
                if (r_fidx == '0) begin
                    n_pidx  = '0;
                    n_pconn = '0;
                    n_pflag = 1'b0;
                    n_ret   = 1'b0;
                    n_state = S_KPUSH;
                end else begin
                    rm_we_main = 1'b1;
                    rm_waddr   = rphys(r_rh, IW'(r_rc));
                    n_rflag[rm_waddr] = 1'b0;
                    n_rc       = r_rc + RCW'(1);
                    n_state    = S_J0;
                end
            end
            S_KPUSH: begin
                if (int'(r_kc) == KEY_DEPTH) begin
                    k_raddr = r_kh;
                    n_state = S_KFULL;
                end else begin
                    n_state = S_KWR;
                end
            end
            S_KFULL: begin
                if (buf_sts.ready) begin
                    buf_req.push   = 1'b1;
                    buf_req.idx    = r_kq_idx;
                    buf_req.forced = 1'b1;
                    n_kh           = kphys(r_kh, IW'(1));
                    n_kc           = r_kc - KCW'(1);
                    n_state        = S_KWR;
                end
            end
            S_KWR: begin
                k_waddr   = kphys(r_kh, IW'(r_kc));
                k_we_idx  = 1'b1;
                k_we_un   = 1'b1;
                k_we_conn = 1'b1;
                k_wd_idx  = r_pidx;
                k_wd_conn = r_pconn;
                n_kflag[k_waddr] = r_pflag;
                n_kc      = r_kc + KCW'(1);
                n_state   = r_ret ? S_U_INIT : S_J0;
            end
            // Judge the oldest recent frame when the window is over its limit.
            S_J0: begin
                if (int'(r_rc) > lim) begin
                    rm_raddr = r_rh;
                    n_jslot  = r_rh;
                    n_rh     = rphys(r_rh, IW'(1));
                    n_rc     = r_rc - RCW'(1);
                    n_state  = S_J1;
                end else begin
                    n_state = S_U_INIT;
                end
            end
            S_J1: begin
                n_jidx  = r_rq_idx;
                n_jconn = r_rflag[r_jslot] ? r_rq_conn : '0;
                n_prod  = MW'(r_cfg_ratio) * MW'(r_rq_size);
                n_state = S_J2;
            end
            S_J2: begin
                n_rhs   = PW'(r_prod) * PW'(r_rc);
                n_state = S_J3;
            end
            S_J3: begin
                if (PW'({r_jconn, 8'h00}) > r_rhs) begin
                    n_pidx  = r_jidx;
                    n_pconn = r_jconn;
                    n_pflag = 1'b1;
                    n_ret   = 1'b1;
                    n_state = S_KPUSH;
                end else if (buf_sts.ready) begin
                    buf_req.push = 1'b1;
                    buf_req.idx  = r_jidx;
                    n_state      = S_U_INIT;
                end
            end
            // Unused counters, one keyframe at a time.
            S_U_INIT: begin
                n_i     = '0;
                n_done  = '0;
                n_gone  = '0;
                n_any   = 1'b0;
                n_state = S_U_RD;
            end
            S_U_RD: begin
                if (int'(r_i) >= int'(r_kc)) begin
                    n_j     = '0;
                    n_state = r_any ? S_G_SEL : S_CAP;
                end else begin
                    k_raddr = kslot;
                    n_state = S_U_EX;
                end
            end
            S_U_EX: begin
                if (!un_done || buf_sts.ready) begin
                    k_we_un = 1'b1;
                    k_wd_un = un_next;
                    n_done[r_i[KAW-1:0]] = un_done;
                    if (un_done) begin
                        n_any        = 1'b1;
                        buf_req.push = 1'b1;
                        buf_req.idx  = r_kq_idx;
                    end
                    n_i     = r_i + IW'(1);
                    n_state = S_U_RD;
                end
            end
            // Mark every keyframe that shares an index with an expired one.
            S_G_SEL: begin
                if (int'(r_j) >= int'(r_kc)) begin
                    n_i     = '0;
                    n_w     = '0;
                    n_state = S_C_RD;
                end else if (!r_done[r_j[KAW-1:0]]) begin
                    n_j = r_j + IW'(1);
                end else begin
                    k_raddr = kphys(r_kh, r_j);
                    n_state = S_G_KEY;
                end
            end
            S_G_KEY: begin
                n_gkey  = r_kq_idx;
                n_i     = '0;
                n_state = S_G_RD;
            end
            S_G_RD: begin
                if (int'(r_i) >= int'(r_kc)) begin
                    n_j     = r_j + IW'(1);
                    n_state = S_G_SEL;
                end else begin
                    k_raddr = kslot;
                    n_state = S_G_EX;
                end
            end
            S_G_EX: begin
                if (r_kq_idx == r_gkey) n_gone[r_i[KAW-1:0]] = 1'b1;
                n_i     = r_i + IW'(1);
                n_state = S_G_RD;
            end
            // Compact the surviving keyframes toward the head.
            S_C_RD: begin
                if (int'(r_i) >= int'(r_kc)) begin
                    n_kc    = KCW'(r_w);
                    n_state = S_CAP;
                end else if (r_gone[r_i[KAW-1:0]]) begin
                    n_i = r_i + IW'(1);
                end else begin
                    k_raddr = kslot;
                    n_state = S_C_EX;
                end
            end
            S_C_EX: begin
                k_waddr  = kphys(r_kh, r_w);
                k_we_idx = 1'b1;
                k_we_un  = 1'b1;
                k_wd_idx = r_kq_idx;
                k_wd_un  = r_kq_un;
                n_w      = r_w + IW'(1);
                n_i      = r_i + IW'(1);
                n_state  = S_C_RD;
            end
            // Evict the oldest keyframe above the cap or with a full store.
            S_CAP: begin
                k_raddr = r_kh;
                if (r_cfg_cap != '0 && int'(r_kc) > int'(r_cfg_cap)) begin
                    n_cforced = 1'b0;
                    n_state   = S_CAP_EX;
                end else if (int'(r_kc) >= KEY_DEPTH) begin
                    n_cforced = 1'b1;
                    n_state   = S_CAP_EX;
                end else begin
                    n_state = S_END;
                end
            end
            S_CAP_EX: begin
                if (buf_sts.ready) begin
                    buf_req.push   = 1'b1;
                    buf_req.idx    = r_kq_idx;
                    buf_req.forced = r_cforced;
                    n_kh           = kphys(r_kh, IW'(1));
                    n_kc           = r_kc - KCW'(1);
                    n_state        = S_END;
                end
            end
            // Flag the last word and drop all reported counts.
            S_END: begin
                if (buf_sts.ready) begin
                    buf_req.flush = 1'b1;
                    n_kflag       = '0;
                    n_rflag       = '0;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kh        <= '0;
            r_kc        <= '0;
            r_rh        <= '0;
            r_rc        <= '0;
            r_kflag     <= '0;
            r_rflag     <= '0;
            r_cfg_rl    <= kwm_pkg::RECENT_LIMIT_RST;
            r_cfg_ratio <= kwm_pkg::MATCH_RATIO_RST;
            r_cfg_ul    <= kwm_pkg::UNUSED_LIMIT_RST;
            r_cfg_cap   <= kwm_pkg::KEY_CAP_RST;
        end else begin
            r_state <= n_state;
            r_kh    <= n_kh;
            r_kc    <= n_kc;
            r_rh    <= n_rh;
            r_rc    <= n_rc;
            r_kflag <= n_kflag;
            r_rflag <= n_rflag;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kwm_pkg::REG_RECENT_LIMIT: r_cfg_rl    <= i_cfg_wdata[2:0];
                    kwm_pkg::REG_MATCH_RATIO:  r_cfg_ratio <= i_cfg_wdata[15:0];
                    kwm_pkg::REG_UNUSED_LIMIT: r_cfg_ul    <= i_cfg_wdata[7:0];
                    kwm_pkg::REG_KEY_CAP:      r_cfg_cap   <= i_cfg_wdata[3:0];
                endcase
            end
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_w       <= n_w;
        r_done    <= n_done;
        r_gone    <= n_gone;
        r_any     <= n_any;
        r_ret     <= n_ret;
        r_cforced <= n_cforced;
        r_fidx    <= n_fidx;
        r_fsize   <= n_fsize;
        r_fconn   <= n_fconn;
        r_pidx    <= n_pidx;
        r_pconn   <= n_pconn;
        r_pflag   <= n_pflag;
        r_jslot   <= n_jslot;
        r_jidx    <= n_jidx;
        r_jconn   <= n_jconn;
        r_prod    <= n_prod;
        r_rhs     <= n_rhs;
        r_gkey    <= n_gkey;
        r_kra     <= k_raddr;
        r_rra     <= rm_raddr;
    end

    // Keyframe memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (k_we_idx)  r_kmem_idx[k_waddr]  <= k_wd_idx;
        if (k_we_un)   r_kmem_un[k_waddr]   <= k_wd_un;
        if (k_we_conn) r_kmem_conn[k_waddr] <= k_wd_conn;
        r_kq_idx  <= r_kmem_idx[k_raddr];
        r_kq_un   <= r_kmem_un[k_raddr];
        r_kq_conn <= r_kmem_conn[k_raddr];
    end

    // Recent frame memory.
    always_ff @(posedge i_clk) begin
        if (rm_we_main) begin
            r_rmem_idx[rm_waddr]  <= r_fidx;
            r_rmem_size[rm_waddr] <= r_fsize;
        end
        if (rm_we_conn) r_rmem_conn[rm_waddr] <= rm_wd_conn;
        r_rq_idx  <= r_rmem_idx[rm_raddr];
        r_rq_size <= r_rmem_size[rm_raddr];
        r_rq_conn <= r_rmem_conn[rm_raddr];
    end

    kwm_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (buf_req),
        .o_sts            (buf_sts),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_marginal_index (o_marginal_index),
        .o_last_of_step   (o_last_of_step),
        .o_forced_evict   (o_forced_evict)
    );

    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_kc) <= KEY_DEPTH) else $error("keyframe count above depth");

    a_recent_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (int'(r_rc) < RECENT_DEPTH))
        else $error("recent window overfilled between steps");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !buf_sts.pending)
        else $error("held word left over after a step");

    a_flags_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && buf_sts.ready) |=> (r_kflag == '0 && r_rflag == '0))
        else $error("connection flags not cleared at step end");

endmodule
